// ===== rtl/far_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// far_pkg
// shared types for the fraction add and reduce block: controller states,
// datapath commands and datapath status
// ----------------------------------------------------------------------------
package far_pkg;

    localparam int NUM_OUT_W = 33;
    localparam int DEN_OUT_W = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_SUM,
        S_GCD_INIT,
        S_GCD,
        S_DIVN_INIT,
        S_DIVN,
        S_DIVD_INIT,
        S_DIVD,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL1,
        OP_MUL2,
        OP_MUL3,
        OP_SUM,
        OP_GCD_INIT,
        OP_GCD_STEP,
        OP_DIVN_INIT,
        OP_DIVD_INIT,
        OP_DIV_STEP,
        OP_OUT
    } op_t;

    typedef struct packed {
        logic zero_any;
        logic gcd_done;
        logic div_last;
    } status_t;

endpackage
`default_nettype wire

// ===== rtl/far_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// far_ctrl
// sequencer: steps the datapath through multiply, sum, gcd and two
// divisions, and owns the input ready and output valid handshake
// ----------------------------------------------------------------------------
module far_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire far_pkg::status_t status,
    output far_pkg::op_t          op
);
    import far_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_MUL1;
            end
            S_MUL1:      state_next = S_MUL2;
            S_MUL2:      state_next = S_MUL3;
            S_MUL3:      state_next = S_SUM;
            S_SUM:       state_next = S_GCD_INIT;
            S_GCD_INIT:
            begin
                if (status.zero_any)
                    state_next = S_DONE;
                else
                    state_next = S_GCD;
            end
            S_GCD:
            begin
                if (status.gcd_done)
                    state_next = S_DIVN_INIT;
            end
            S_DIVN_INIT: state_next = S_DIVN;
            S_DIVN:
            begin
                if (status.div_last)
                    state_next = S_DIVD_INIT;
            end
            S_DIVD_INIT: state_next = S_DIVD;
            S_DIVD:
            begin
                if (status.div_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        op = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    op = OP_LOAD;
            end
            S_MUL1:      op = OP_MUL1;
            S_MUL2:      op = OP_MUL2;
            S_MUL3:      op = OP_MUL3;
            S_SUM:       op = OP_SUM;
            S_GCD_INIT:  op = OP_GCD_INIT;
            S_GCD:
            begin
                if (!status.gcd_done)
                    op = OP_GCD_STEP;
            end
            S_DIVN_INIT: op = OP_DIVN_INIT;
            S_DIVN:      op = OP_DIV_STEP;
            S_DIVD_INIT: op = OP_DIVD_INIT;
            S_DIVD:      op = OP_DIV_STEP;
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    op = OP_OUT;
            end
            default:     op = OP_NONE;
        endcase
    end

    // output beat holds until taken; a new result may replace it on the same edge
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (op == OP_OUT)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/far_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// far_dp
// datapath: shared multiplier, sign-magnitude sum, binary gcd step unit,
// restoring divider and the output registers
// ----------------------------------------------------------------------------
module far_dp #(
    parameter int DATA_WIDTH = 16
) (
    input  wire logic                           clk,
    input  wire far_pkg::op_t                   op,
    input  wire logic signed [DATA_WIDTH-1:0]   num_a,
    input  wire logic signed [DATA_WIDTH-1:0]   den_a,
    input  wire logic signed [DATA_WIDTH-1:0]   num_b,
    input  wire logic signed [DATA_WIDTH-1:0]   den_b,
    output far_pkg::status_t                    status,
    output logic signed [far_pkg::NUM_OUT_W-1:0] sum_num,
    output logic signed [far_pkg::DEN_OUT_W-1:0] sum_den,
    output logic                                zero_gcd_error
);
    import far_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int QW = 2 * DATA_WIDTH;
    localparam int CW = $clog2(QW);
    localparam int XW = QW + NUM_OUT_W;

    // operand sign and magnitude
    logic         sna_reg, sda_reg, snb_reg, sdb_reg;
    logic [W-1:0] mna_reg, mda_reg, mnb_reg, mdb_reg;
    logic [W-1:0] mna_next, mda_next, mnb_next, mdb_next;

    logic [QW-1:0] m1_reg, m2_reg, dm_reg, nm_reg;
    logic          ns_reg, ds_reg;
    logic [QW-1:0] a_reg, b_reg, xn_reg, xd_reg;
    logic [QW-1:0] rem_reg, dvd_reg, dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          sel_reg;
    logic [QW-1:0] qn_reg, qd_reg;
    logic          err_reg;
    logic [NUM_OUT_W-1:0] sum_num_reg;
    logic [DEN_OUT_W-1:0] sum_den_reg;
    logic          zero_gcd_error_reg;

    logic [W-1:0]  mul_x, mul_y;
    logic [QW-1:0] prod;
    logic [QW:0]   m_diff;
    logic [QW:0]   m_sum;
    logic [QW-1:0] m_rdiff;
    logic [QW-1:0] nm_next;
    logic          ns_next;

    logic          a_odd, b_odd;
    logic [QW:0]   amb;
    logic [QW-1:0] bma;

    logic [QW:0]   shifted;
    logic [QW:0]   trial;
    logic          fits;
    logic [QW-1:0] rem_next;
    logic [QW-1:0] dvd_next;

    logic [XW-1:0] num_ext, den_ext, num_sgn, den_sgn;

    always_comb
    begin
        mna_next = num_a[W-1] ? (~$unsigned(num_a) + 1'b1) : $unsigned(num_a);
        mda_next = den_a[W-1] ? (~$unsigned(den_a) + 1'b1) : $unsigned(den_a);
        mnb_next = num_b[W-1] ? (~$unsigned(num_b) + 1'b1) : $unsigned(num_b);
        mdb_next = den_b[W-1] ? (~$unsigned(den_b) + 1'b1) : $unsigned(den_b);
    end

    // one multiplier shared by the three products
    always_comb
    begin
        mul_x = mda_reg;
        mul_y = mdb_reg;
        case (op)
            OP_MUL1:
            begin
                mul_x = mna_reg;
                mul_y = mdb_reg;
            end
            OP_MUL2:
            begin
                mul_x = mnb_reg;
                mul_y = mda_reg;
            end
            default:
            begin
                mul_x = mda_reg;
                mul_y = mdb_reg;
            end
        endcase
        prod = QW'(mul_x) * QW'(mul_y);
    end

    // signed sum of the two cross products
    always_comb
    begin
        logic s1, s2;
        s1      = sna_reg ^ sdb_reg;
        s2      = snb_reg ^ sda_reg;
        m_sum   = {1'b0, m1_reg} + {1'b0, m2_reg};
        m_diff  = {1'b0, m1_reg} - {1'b0, m2_reg};
        m_rdiff = m2_reg - m1_reg;
        if (s1 == s2)
        begin
            nm_next = m_sum[QW-1:0];
            ns_next = s1;
        end
        else if (!m_diff[QW])
        begin
            nm_next = m_diff[QW-1:0];
            ns_next = s1;
        end
        else
        begin
            nm_next = m_rdiff;
            ns_next = s2;
        end
    end

    // gcd step terms
    assign a_odd = a_reg[0];
    assign b_odd = b_reg[0];
    assign amb   = {1'b0, a_reg} - {1'b0, b_reg};
    assign bma   = b_reg - a_reg;

    // restoring divider, one quotient bit per beat of the sequencer
    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[QW-1]};
        trial    = shifted - {1'b0, dvs_reg};
        fits     = !trial[QW];
        rem_next = fits ? trial[QW-1:0] : shifted[QW-1:0];
        dvd_next = {dvd_reg[QW-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                sna_reg <= num_a[W-1];
                sda_reg <= den_a[W-1];
                snb_reg <= num_b[W-1];
                sdb_reg <= den_b[W-1];
                mna_reg <= mna_next;
                mda_reg <= mda_next;
                mnb_reg <= mnb_next;
                mdb_reg <= mdb_next;
            end
            OP_MUL1: m1_reg <= prod;
            OP_MUL2: m2_reg <= prod;
            OP_MUL3: dm_reg <= prod;
            OP_SUM:
            begin
                nm_reg <= nm_next;
                ns_reg <= ns_next;
                ds_reg <= sda_reg ^ sdb_reg;
            end
            OP_GCD_INIT:
            begin
                // a zero operand reduces the other one to unit magnitude
                qn_reg  <= QW'(|nm_reg);
                qd_reg  <= QW'(|dm_reg);
                err_reg <= ~(|nm_reg) & ~(|dm_reg);
                a_reg   <= nm_reg;
                b_reg   <= dm_reg;
                xn_reg  <= nm_reg;
                xd_reg  <= dm_reg;
            end
            OP_GCD_STEP:
            begin
                if (!a_odd && !b_odd)
                begin
                    // common factors of two come off the dividends too
                    a_reg  <= a_reg >> 1;
                    b_reg  <= b_reg >> 1;
                    xn_reg <= xn_reg >> 1;
                    xd_reg <= xd_reg >> 1;
                end
                else if (!a_odd)
                    a_reg <= a_reg >> 1;
                else if (!b_odd)
                    b_reg <= b_reg >> 1;
                else if (!amb[QW])
                    a_reg <= amb[QW:1];
                else
                    b_reg <= bma >> 1;
            end
            OP_DIVN_INIT:
            begin
                rem_reg <= '0;
                dvd_reg <= xn_reg;
                dvs_reg <= a_reg;
                cnt_reg <= '0;
                sel_reg <= 1'b0;
            end
            OP_DIVD_INIT:
            begin
                rem_reg <= '0;
                dvd_reg <= xd_reg;
                dvs_reg <= a_reg;
                cnt_reg <= '0;
                sel_reg <= 1'b1;
            end
            OP_DIV_STEP:
            begin
                rem_reg <= rem_next;
                dvd_reg <= dvd_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (status.div_last)
                begin
                    if (sel_reg)
                        qd_reg <= dvd_next;
                    else
                        qn_reg <= dvd_next;
                end
            end
            OP_OUT:
            begin
                sum_num_reg        <= num_sgn[NUM_OUT_W-1:0];
                sum_den_reg        <= den_sgn[DEN_OUT_W-1:0];
                zero_gcd_error_reg <= err_reg;
            end
            default:
            begin
            end
        endcase
    end

    // apply sign and wrap to the output field widths
    always_comb
    begin
        num_ext = {{(XW-QW){1'b0}}, qn_reg};
        den_ext = {{(XW-QW){1'b0}}, qd_reg};
        num_sgn = ns_reg ? (~num_ext + 1'b1) : num_ext;
        den_sgn = ds_reg ? (~den_ext + 1'b1) : den_ext;
    end

    assign status.zero_any = ~(|nm_reg) | ~(|dm_reg);
    assign status.gcd_done = (a_reg == b_reg);
    assign status.div_last = (cnt_reg == CW'(QW - 1));

    assign sum_num        = $signed(sum_num_reg);
    assign sum_den        = $signed(sum_den_reg);
    assign zero_gcd_error = zero_gcd_error_reg;

endmodule
`default_nettype wire

// ===== rtl/fraction_add_reduce.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fraction_add_reduce
// adds two signed fractions and reduces the sum by the gcd of the magnitudes
// of its numerator and denominator; denominator sign is kept as produced
//
//   channel   signals                              beat
//   input     in_valid in_ready                    num_a den_a num_b den_b
//   output    out_valid out_ready                  sum_num sum_den zero_gcd_error
//
// one item at a time: load, three products on one shared multiplier, sum,
// a binary gcd, then two restoring divisions of 2*DATA_WIDTH-bit dividends.
// when the sum's numerator or denominator is zero the gcd and divisions are skipped.
// reset clears only the sequencer and output valid.
// a result waiting on out_ready stalls the sequencer only at its final beat.
// ----------------------------------------------------------------------------
module fraction_add_reduce #(
    parameter int DATA_WIDTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [DATA_WIDTH-1:0]      num_a,
    input  wire logic signed [DATA_WIDTH-1:0]      den_a,
    input  wire logic signed [DATA_WIDTH-1:0]      num_b,
    input  wire logic signed [DATA_WIDTH-1:0]      den_b,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [far_pkg::NUM_OUT_W-1:0]   sum_num,
    output logic signed [far_pkg::DEN_OUT_W-1:0]   sum_den,
    output logic                                   zero_gcd_error
);
    import far_pkg::*;

    op_t     op;
    status_t status;

    far_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .op        (op)
    );

    far_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk            (clk),
        .op             (op),
        .num_a          (num_a),
        .den_a          (den_a),
        .num_b          (num_b),
        .den_b          (den_b),
        .status         (status),
        .sum_num        (sum_num),
        .sum_den        (sum_den),
        .zero_gcd_error (zero_gcd_error)
    );

`ifndef SYNTHESIS
    // error beat carries zeros in both result fields
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_gcd_error |-> (sum_num == '0) && (sum_den == '0))
        else $error("error beat with nonzero result");

    // an accepted item keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after accept");

    // a new result only appears after work, never straight from idle
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result raised while idle");
`endif

endmodule
`default_nettype wire
